FILE: design/lpr_pkg.sv
// Shared constants and types for the lattice pair reduction block.
package lpr_pkg;

   localparam int VEC_DIM     = 32;
   localparam int CNT_W       = $clog2(VEC_DIM);
   localparam int ADDR_W      = CNT_W + 1;
   localparam int IN_W        = 24;
   localparam int P_W         = 2 * IN_W - 1;
   localparam int S_W         = P_W + CNT_W;
   localparam int NUM_W       = S_W + 2;
   localparam int DIV_CNT_W   = $clog2(NUM_W);
   localparam int M_SAT_BITS  = 40;
   localparam int M_W         = M_SAT_BITS + 1;
   localparam int DIFF_W      = M_W + IN_W + 1;
   localparam int OUT_W       = 32;
   localparam int NORM_W      = 63;
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);

   typedef struct packed {
      logic signed [IN_W-1:0] coord_a;
      logic signed [IN_W-1:0] coord_b;
      logic                   last_pair;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] coord_out;
      logic                    is_last;
      logic [NORM_W-1:0]       new_norm;
      logic                    accepted;
      logic                    overflowed;
   } rsp_type;

   typedef struct packed {
      logic signed [S_W:0] dot;
      logic [S_W-1:0]      norm_a;
      logic [S_W-1:0]      norm_b;
      logic                bank;
      logic [CNT_W-1:0]    last_idx;
   } job_type;

   typedef struct packed {
      logic                   en;
      logic [ADDR_W-1:0]      addr;
      logic signed [IN_W-1:0] a;
      logic signed [IN_W-1:0] b;
   } mem_wr_type;

   typedef struct packed {
      logic en;
      logic bank;
   } release_type;

endpackage

FILE: design/lpr_front.sv
// Front end: loads coordinate pairs into a bank and accumulates dot and norms.
module lpr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  lpr_pkg::req_type    req_data,
   output lpr_pkg::mem_wr_type mem_wr,
   output logic                job_push,
   output lpr_pkg::job_type    job,
   input  lpr_pkg::release_type rel
);

   logic                           bank_ff;
   logic [1:0]                     busy_ff;
   logic [lpr_pkg::CNT_W-1:0]      idx_ff;
   logic                           accept;
   logic                           end_pair;

   logic                           v1_ff, v2_ff;
   logic                           last1_ff, last2_ff;
   logic                           bank1_ff, bank2_ff;
   logic [lpr_pkg::CNT_W-1:0]      idx1_ff, idx2_ff;
   logic signed [lpr_pkg::IN_W-1:0] a1_ff, b1_ff;
   logic signed [2*lpr_pkg::IN_W-1:0] aa_in, bb_in, ab_in;
   logic [lpr_pkg::P_W-1:0]        aa_ff, bb_ff;
   logic signed [2*lpr_pkg::IN_W-1:0] ab_ff;

   logic signed [lpr_pkg::S_W:0]   dot_ff, dot_in;
   logic [lpr_pkg::S_W-1:0]        na_ff, nb_ff, na_in, nb_in;

   // Accept while the current bank is free
   assign full     = busy_ff[bank_ff];
   assign accept   = push && !full;
   assign end_pair = req_data.last_pair ||
                     (idx_ff == lpr_pkg::CNT_W'(lpr_pkg::VEC_DIM - 1));

   // Write the pair straight into the store
   assign mem_wr.en   = accept;
   assign mem_wr.addr = {bank_ff, idx_ff};
   assign mem_wr.a    = req_data.coord_a;
   assign mem_wr.b    = req_data.coord_b;

   // Load control: slot index, bank toggle and bank ownership
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
         idx_ff  <= '0;
      end else begin
         if (rel.en) begin
            busy_ff[rel.bank] <= 1'b0;
         end
         if (accept) begin
            if (end_pair) begin
               busy_ff[bank_ff] <= 1'b1;
               bank_ff          <= !bank_ff;
               idx_ff           <= '0;
            end else begin
               idx_ff <= idx_ff + lpr_pkg::CNT_W'(1);
            end
         end
      end
   end

   // Register the pair, then the three products
   assign aa_in = a1_ff * a1_ff;
   assign bb_in = b1_ff * b1_ff;
   assign ab_in = a1_ff * b1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
      a1_ff    <= req_data.coord_a;
      b1_ff    <= req_data.coord_b;
      last1_ff <= end_pair;
      bank1_ff <= bank_ff;
      idx1_ff  <= idx_ff;
      aa_ff    <= aa_in[lpr_pkg::P_W-1:0];
      bb_ff    <= bb_in[lpr_pkg::P_W-1:0];
      ab_ff    <= ab_in;
      last2_ff <= last1_ff;
      bank2_ff <= bank1_ff;
      idx2_ff  <= idx1_ff;
   end

   // Accumulate; hand the totals to the queue on the final pair
   assign dot_in = dot_ff + (lpr_pkg::S_W+1)'(ab_ff);
   assign na_in  = na_ff + lpr_pkg::S_W'(aa_ff);
   assign nb_in  = nb_ff + lpr_pkg::S_W'(bb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
      end else if (v2_ff) begin
         if (last2_ff) begin
            dot_ff <= '0;
            na_ff  <= '0;
            nb_ff  <= '0;
         end else begin
            dot_ff <= dot_in;
            na_ff  <= na_in;
            nb_ff  <= nb_in;
         end
      end
   end

   assign job_push     = v2_ff && last2_ff;
   assign job.dot      = dot_in;
   assign job.norm_a   = na_in;
   assign job.norm_b   = nb_in;
   assign job.bank     = bank2_ff;
   assign job.last_idx = idx2_ff;

endmodule

FILE: design/lpr_job_queue.sv
// Two-entry queue of loaded vector jobs between front and back.
module lpr_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lpr_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output lpr_pkg::job_type head
);

   lpr_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push, do_pop;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Hold entries, advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: design/lpr_divider.sv
// Restoring divider, one quotient bit per cycle.
module lpr_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lpr_pkg::NUM_W-1:0] num,
   input  logic [lpr_pkg::NUM_W-1:0] den,
   output logic                      done,
   output logic [lpr_pkg::NUM_W-1:0] quo
);

   logic                          busy_ff, done_ff;
   logic [lpr_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [lpr_pkg::NUM_W-1:0]     num_ff, den_ff, rem_ff, quo_ff;
   logic [lpr_pkg::NUM_W:0]       trial;
   logic [lpr_pkg::NUM_W:0]       diff;
   logic                          fits;

   assign trial = {rem_ff, num_ff[lpr_pkg::NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = !diff[lpr_pkg::NUM_W];
   assign done  = done_ff;
   assign quo   = quo_ff;

   // Shift in one numerator bit, subtract where the divisor fits
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= lpr_pkg::DIV_CNT_W'(lpr_pkg::NUM_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - lpr_pkg::DIV_CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[lpr_pkg::NUM_W-2:0], 1'b0};
         rem_ff <= fits ? diff[lpr_pkg::NUM_W-1:0] : trial[lpr_pkg::NUM_W-1:0];
         quo_ff <= {quo_ff[lpr_pkg::NUM_W-2:0], fits};
      end
   end

endmodule

FILE: design/lpr_back.sv
// Back end: forms m, emits reduced coordinates and buffers result words.
module lpr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  lpr_pkg::mem_wr_type  mem_wr,
   input  logic                 job_empty,
   input  lpr_pkg::job_type     job,
   output logic                 job_pop,
   output lpr_pkg::release_type rel,
   input  logic                 pop,
   output logic                 empty,
   output lpr_pkg::rsp_type     rsp_data
);

   typedef enum logic [3:0] {
      BK_IDLE  = 4'b0001,
      BK_DIV   = 4'b0010,
      BK_EMIT  = 4'b0100,
      BK_DRAIN = 4'b1000
   } back_state_type;

   back_state_type state_ff;

   logic [2*lpr_pkg::IN_W-1:0] mem [2*lpr_pkg::VEC_DIM];

   logic [lpr_pkg::S_W-1:0]    na_ff, nb_ff;
   logic                       m_neg_ff, m_big_ff, bank_ff;
   logic signed [lpr_pkg::M_W-1:0] m_ff;
   logic [lpr_pkg::CNT_W-1:0]  last_idx_ff, rd_idx_ff;

   logic [lpr_pkg::S_W-1:0]    dot_mag;
   logic [lpr_pkg::NUM_W-1:0]  div_num, div_den, div_quo;
   logic                       div_start, div_done;
   logic [lpr_pkg::M_W-1:0]    q_low;

   logic                       issue, issue_last, credit_ok;
   logic [2:0]                 inflight;
   logic [lpr_pkg::RSP_PTR_W+1:0] credit_sum;

   logic                       v1_ff, v2_ff, v3_ff, v4_ff;
   logic                       l1_ff, l2_ff, l3_ff, l4_ff;
   logic [2*lpr_pkg::IN_W-1:0] word1_ff;
   logic signed [lpr_pkg::IN_W-1:0] a1, b1;
   logic signed [lpr_pkg::M_W+lpr_pkg::IN_W-1:0] prod_in, prod2_ff;
   logic signed [lpr_pkg::IN_W-1:0] b2_ff;
   logic                       az2_ff, an2_ff;
   logic signed [lpr_pkg::DIFF_W-1:0] diff;
   logic signed [lpr_pkg::OUT_W-1:0] t_in, t3_ff, t4_ff;
   logic                       o_in, o3_ff, o4_ff;
   logic signed [2*lpr_pkg::OUT_W-1:0] sq_in;
   logic [lpr_pkg::NORM_W-1:0] sq4_ff;

   logic [lpr_pkg::NORM_W-1:0] norm_ff, norm_in;
   logic [lpr_pkg::NORM_W:0]   norm_sum;
   logic                       ovf_ff, ovf_in, acc_in;
   lpr_pkg::rsp_type           rsp_in;

   lpr_pkg::rsp_type           q_ff [lpr_pkg::RSP_DEPTH];
   logic [lpr_pkg::RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [lpr_pkg::RSP_PTR_W:0]   count_ff;
   logic                       q_push, q_pop;

   // Divider operands: 2|dot| + |a|^2 over 2|a|^2
   assign dot_mag   = job.dot[lpr_pkg::S_W] ? lpr_pkg::S_W'(-job.dot)
                                            : lpr_pkg::S_W'(job.dot);
   assign div_num   = {1'b0, dot_mag, 1'b0} + lpr_pkg::NUM_W'(job.norm_a);
   assign div_den   = {1'b0, job.norm_a, 1'b0};
   assign job_pop   = (state_ff == BK_IDLE) && !job_empty;
   assign div_start = job_pop && (job.norm_a != '0);
   assign q_low     = {1'b0, div_quo[lpr_pkg::M_SAT_BITS-1:0]};

   lpr_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Read credit: never issue more than the result buffer can hold
   assign inflight   = 3'(v1_ff) + 3'(v2_ff) + 3'(v3_ff) + 3'(v4_ff);
   assign credit_sum = (lpr_pkg::RSP_PTR_W+2)'(count_ff) +
                       (lpr_pkg::RSP_PTR_W+2)'(inflight);
   assign credit_ok  = credit_sum < (lpr_pkg::RSP_PTR_W+2)'(lpr_pkg::RSP_DEPTH);
   assign issue      = (state_ff == BK_EMIT) && credit_ok;
   assign issue_last = issue && (rd_idx_ff == last_idx_ff);
   assign rel.en     = issue_last;
   assign rel.bank   = bank_ff;

   // Sequence each job: divide (skipped when |a|^2 is zero), emit, drain
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         unique case (state_ff)
            BK_IDLE: begin
               if (job_pop) begin
                  state_ff <= (job.norm_a != '0) ? BK_DIV : BK_EMIT;
               end
            end
            BK_DIV: begin
               if (div_done) begin
                  state_ff <= BK_EMIT;
               end
            end
            BK_EMIT: begin
               if (issue_last) begin
                  state_ff <= BK_DRAIN;
               end
            end
            BK_DRAIN: begin
               if (inflight == 3'd0) begin
                  state_ff <= BK_IDLE;
               end
            end
            default: state_ff <= BK_IDLE;
         endcase
      end
   end

   // Job fields and the multiplier
   always_ff @(posedge clock) begin
      if (job_pop) begin
         na_ff       <= job.norm_a;
         nb_ff       <= job.norm_b;
         bank_ff     <= job.bank;
         last_idx_ff <= job.last_idx;
         m_neg_ff    <= job.dot[lpr_pkg::S_W];
         m_ff        <= '0;
         m_big_ff    <= 1'b0;
         rd_idx_ff   <= '0;
      end else begin
         if (div_done) begin
            m_big_ff <= (div_quo[lpr_pkg::NUM_W-1:lpr_pkg::M_SAT_BITS] != '0);
            m_ff     <= m_neg_ff ? -$signed(q_low) : $signed(q_low);
         end
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + lpr_pkg::CNT_W'(1);
         end
      end
   end

   // Pair store: one write port from the front, one read port here
   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.addr] <= {mem_wr.a, mem_wr.b};
      end
      if (issue) begin
         word1_ff <= mem[{bank_ff, rd_idx_ff}];
      end
   end

   assign a1      = word1_ff[2*lpr_pkg::IN_W-1:lpr_pkg::IN_W];
   assign b1      = word1_ff[lpr_pkg::IN_W-1:0];
   assign prod_in = m_ff * a1;
   assign diff    = lpr_pkg::DIFF_W'(b2_ff) - lpr_pkg::DIFF_W'(prod2_ff);

   // Clamp b - m*a to 32 bits
   always_comb begin
      t_in = lpr_pkg::OUT_W'(b2_ff);
      o_in = 1'b0;
      if (az2_ff) begin
         t_in = lpr_pkg::OUT_W'(b2_ff);
      end else if (m_big_ff) begin
         o_in = 1'b1;
         t_in = (an2_ff != m_neg_ff) ? {1'b0, {(lpr_pkg::OUT_W-1){1'b1}}}
                                     : {1'b1, {(lpr_pkg::OUT_W-1){1'b0}}};
      end else if (diff > lpr_pkg::DIFF_W'(64'sh7FFF_FFFF)) begin
         o_in = 1'b1;
         t_in = {1'b0, {(lpr_pkg::OUT_W-1){1'b1}}};
      end else if (diff < -lpr_pkg::DIFF_W'(64'sh8000_0000)) begin
         o_in = 1'b1;
         t_in = {1'b1, {(lpr_pkg::OUT_W-1){1'b0}}};
      end else begin
         t_in = diff[lpr_pkg::OUT_W-1:0];
      end
   end

   assign sq_in = t3_ff * t3_ff;

   // Emit pipeline: read, multiply, clamp, square
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      l1_ff    <= issue_last;
      l2_ff    <= l1_ff;
      l3_ff    <= l2_ff;
      l4_ff    <= l3_ff;
      prod2_ff <= prod_in;
      b2_ff    <= b1;
      az2_ff   <= (a1 == '0);
      an2_ff   <= a1[lpr_pkg::IN_W-1];
      t3_ff    <= t_in;
      o3_ff    <= o_in;
      t4_ff    <= t3_ff;
      o4_ff    <= o3_ff;
      sq4_ff   <= sq_in[lpr_pkg::NORM_W-1:0];
   end

   // Saturating norm accumulation and the accept decision
   assign norm_sum = {1'b0, norm_ff} + {1'b0, sq4_ff};
   assign norm_in  = norm_sum[lpr_pkg::NORM_W] ? '1 : norm_sum[lpr_pkg::NORM_W-1:0];
   assign ovf_in   = ovf_ff || o4_ff || norm_sum[lpr_pkg::NORM_W];
   assign acc_in   = !ovf_in && (na_ff != '0) && (norm_in != '0) &&
                     ((norm_in < lpr_pkg::NORM_W'(na_ff)) ||
                      (norm_in < lpr_pkg::NORM_W'(nb_ff)));

   always_ff @(posedge clock) begin
      if (job_pop) begin
         norm_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (v4_ff) begin
         norm_ff <= norm_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_in.coord_out  = t4_ff;
   assign rsp_in.is_last    = l4_ff;
   assign rsp_in.new_norm   = l4_ff ? norm_in : '0;
   assign rsp_in.accepted   = l4_ff && acc_in;
   assign rsp_in.overflowed = l4_ff && ovf_in;

   // Result buffer
   assign q_push   = v4_ff;
   assign empty    = (count_ff == '0);
   assign q_pop    = pop && !empty;
   assign rsp_data = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push) begin
            wr_ptr_ff <= wr_ptr_ff + lpr_pkg::RSP_PTR_W'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + lpr_pkg::RSP_PTR_W'(1);
         end
         if (q_push && !q_pop) begin
            count_ff <= count_ff + (lpr_pkg::RSP_PTR_W+1)'(1);
         end else if (q_pop && !q_push) begin
            count_ff <= count_ff - (lpr_pkg::RSP_PTR_W+1)'(1);
         end
      end
      if (q_push) begin
         q_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

FILE: design/lattice_pair_reduce.sv
// Flow: pairs load into a bank and the accumulated job is queued; the back then divides
// (skipped when |a|^2 is zero) and emits through the read, multiply, clamp and square stages.
// Throughput: one pair per cycle while loading into a free bank; the vector rate is
// bounded by the bit-serial divider and the single read port of the pair store.
// Two store banks let the next vector load while the previous one is emitted.
// Reset is synchronous: control and the front accumulators clear, the store is not swept.
module lattice_pair_reduce (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  lpr_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output lpr_pkg::rsp_type rsp_data
);

   lpr_pkg::mem_wr_type  mem_wr;
   lpr_pkg::job_type     front_job, head_job;
   lpr_pkg::release_type rel;
   logic                 job_push, job_full, job_pop, job_empty;

   lpr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .mem_wr   (mem_wr),
      .job_push (job_push),
      .job      (front_job),
      .rel      (rel)
   );

   lpr_job_queue u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (job_full),
      .pop      (job_pop),
      .empty    (job_empty),
      .head     (head_job)
   );

   lpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mem_wr    (mem_wr),
      .job_empty (job_empty),
      .job       (head_job),
      .job_pop   (job_pop),
      .rel       (rel),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

   // The bank handoff must keep the job queue from overflowing
   assert property (@(posedge clock) disable iff (reset) !(job_push && job_full))
      else $error("job queue overflow");

   // Summary fields stay zero on all but the final word
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.is_last) |->
         (rsp_data.new_norm == '0 && !rsp_data.accepted && !rsp_data.overflowed))
      else $error("summary fields set on a non-final word");

   // An overflowed vector is never accepted
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.overflowed) |-> !rsp_data.accepted)
      else $error("overflowed vector accepted");

   // A released bank must not be written in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (rel.en && mem_wr.en) |-> (mem_wr.addr[lpr_pkg::ADDR_W-1] != rel.bank))
      else $error("write into a bank still being read");

endmodule
